FILE: design/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg: shared definitions for the wildcard pattern matcher
// Sizes, pattern symbols, command and register codes, cell link types and the
// case folding helper used by the cell row and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  // pattern store depth and derived widths
  localparam int unsigned PAT_MAX = 32;
  localparam int unsigned IDX_W   = $clog2(PAT_MAX);
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned SYM_W   = 8;

  // stream and configuration port widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // special pattern symbols
  localparam logic [SYM_W-1:0] SYM_STAR   = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_CARET  = 8'h5E;
  localparam logic [SYM_W-1:0] SYM_DOLLAR = 8'h24;
  localparam logic [SYM_W-1:0] SYM_NUL    = 8'h00;

  // ascii case folding
  localparam logic [SYM_W-1:0] UPPER_A  = 8'h41;
  localparam logic [SYM_W-1:0] UPPER_Z  = 8'h5A;
  localparam logic [SYM_W-1:0] CASE_OFS = 8'h20;

  // command carried in tuser
  typedef enum logic [IN_USER_W-1:0] {
    CMD_PAT  = 2'd0,
    CMD_TEXT = 2'd1,
    CMD_END  = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CASE_SENS = 1'b0,
    CFG_PAT_LEN   = 1'b1
  } cfg_idx_e;

  // signals handed from one cell to the next
  typedef struct packed {
    logic in_ok;     // this and all earlier positions lie inside the pattern
    logic c1_carry;  // star closure after start injection
    logic adv;       // literal matched, advance to the next position
    logic c2_carry;  // star closure after the text step
  } link_t;

  // per-cell control from the top level
  typedef struct packed {
    logic             wr_en;
    logic [SYM_W-1:0] wr_sym;
    logic             in_len;
    logic             inject;
    logic             next_is_len;
    logic [SYM_W-1:0] txt_fold;
    logic             case_sens;
    logic             step;
    logic             clear;
  } cell_ctrl_t;

  // per-cell status towards the top level
  typedef struct packed {
    logic is_len;
    logic caret;
    logic dollar;
    logic c1;
    logic c2;
  } cell_stat_t;

  // fold ascii upper case to lower case unless comparison is exact
  function automatic logic [SYM_W-1:0] fold_case(input logic [SYM_W-1:0] c,
                                                 input logic             cs);
    logic [SYM_W-1:0] r;
    r = c;
    if (!cs && (c >= UPPER_A) && (c <= UPPER_Z)) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell: one pattern position of the matcher
// Holds one pattern byte and the active bit of its position, takes the star
// closure and literal advance from its left neighbour and passes them on.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wpm_pkg::cell_ctrl_t ctrl_i,
  input  wpm_pkg::link_t      link_i,
  output wpm_pkg::link_t      link_o,
  output wpm_pkg::cell_stat_t stat_o
);
  import wpm_pkg::*;

  logic [SYM_W-1:0] sym_q;
  logic             act_q, act_d;
  logic             in_rng, is_star, is_dollar, is_lit, eq;
  logic             c1, c2, stay;

  // pattern byte, written by pattern transactions only
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      sym_q <= ctrl_i.wr_sym;
    end
  end

  // position classification
  assign in_rng    = link_i.in_ok && ctrl_i.in_len && (sym_q != SYM_NUL);
  assign is_star   = in_rng && (sym_q == SYM_STAR);
  assign is_dollar = in_rng && (sym_q == SYM_DOLLAR) && ctrl_i.next_is_len;
  assign eq        = (fold_case(sym_q, ctrl_i.case_sens) == ctrl_i.txt_fold);
  assign is_lit    = in_rng && !is_star && !is_dollar && eq;

  // closure after injection, then text step and second closure
  assign c1   = act_q || ctrl_i.inject || link_i.c1_carry;
  assign stay = c1 && is_star;
  assign c2   = stay || link_i.adv || link_i.c2_carry;

  assign link_o.in_ok    = in_rng;
  assign link_o.c1_carry = stay;
  assign link_o.adv      = c1 && is_lit;
  assign link_o.c2_carry = c2 && is_star;

  assign stat_o.is_len = link_i.in_ok && !in_rng;
  assign stat_o.caret  = in_rng && (sym_q == SYM_CARET);
  assign stat_o.dollar = is_dollar;
  assign stat_o.c1     = c1;
  assign stat_o.c2     = c2;

  // active bit update
  always_comb begin
    act_d = act_q;
    if (ctrl_i.clear) begin
      act_d = 1'b0;
    end else if (ctrl_i.step) begin
      act_d = c2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/wildcard_pattern_matcher.sv
// Latency: a match result is shown on the master side in the cycle after the
// end-of-text transaction is accepted, unless an earlier result still waits.
// Throughput: one transaction per cycle, stalled only while two results wait;
// the per-byte path is the two star closures rippling through the 32 cells.
// Reset: active set, text and match flags and the result buffer clear at once,
// the exact compare flag resets to 1 and pattern_length to 0; bytes not reset.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher: streamed glob matcher with start and end anchors
// A row of position cells keeps the set of live pattern positions and
// advances it once per text byte; a two-entry buffer holds match results.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [wpm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [wpm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [wpm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // symbol[7:0], index[12:8]
  input  wire [wpm_pkg::IN_USER_W-1:0]     s_axis_tuser,  // command[1:0]
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [wpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // matched[0]
);
  import wpm_pkg::*;

  logic             case_sens_q;
  logic [LEN_W-1:0] pat_len_q;
  logic             text_started_q, text_started_d;
  logic             match_seen_q, match_seen_d;
  logic             acc_q, acc_d;
  logic             out_valid_q, skid_valid_q;
  logic             out_data_q, skid_data_q;

  logic             in_acc, pop, do_pat, do_text, do_end;
  cmd_e             cmd;
  logic [SYM_W-1:0] sym, txt_fold;
  logic [IDX_W-1:0] wr_idx;
  logic             anchored, inj_en;
  logic             c1_acc, c2_acc;
  logic             m_pre, m_post, dollar_hit, result;

  link_t            links [PAT_MAX+1];
  cell_ctrl_t       ctrl  [PAT_MAX];
  cell_stat_t       stat  [PAT_MAX];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_sens_q <= 1'b1;
      pat_len_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CASE_SENS: case_sens_q <= cfg_data_i[0];
        CFG_PAT_LEN:   pat_len_q   <= cfg_data_i[LEN_W-1:0];
      endcase
    end
  end

  // input transaction decode
  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign sym           = s_axis_tdata[SYM_W-1:0];
  assign wr_idx        = s_axis_tdata[SYM_W +: IDX_W];
  assign txt_fold      = fold_case(sym, case_sens_q);

  always_comb begin
    do_pat  = 1'b0;
    do_text = 1'b0;
    do_end  = 1'b0;
    if (in_acc) begin
      unique case (cmd)
        CMD_PAT:  do_pat  = 1'b1;
        CMD_TEXT: do_text = 1'b1;
        CMD_END:  do_end  = 1'b1;
        default:  ;
      endcase
    end
  end

  // start injection: position 1 behind a leading caret, else position 0
  assign anchored = stat[0].caret;
  assign inj_en   = !text_started_q || !anchored;

  // row of position cells
  assign links[0] = '{in_ok: 1'b1, c1_carry: 1'b0, adv: 1'b0, c2_carry: 1'b0};

  for (genvar g = 0; g < PAT_MAX; g++) begin : g_cell
    always_comb begin
      ctrl[g].wr_en     = do_pat && (wr_idx == IDX_W'(g));
      ctrl[g].wr_sym    = sym;
      ctrl[g].in_len    = (pat_len_q > LEN_W'(g));
      ctrl[g].txt_fold  = txt_fold;
      ctrl[g].case_sens = case_sens_q;
      ctrl[g].step      = do_text;
      ctrl[g].clear     = do_end;
      if (g == 0) begin
        ctrl[g].inject = inj_en && !anchored;
      end else if (g == 1) begin
        ctrl[g].inject = inj_en && anchored;
      end else begin
        ctrl[g].inject = 1'b0;
      end
      if (g == PAT_MAX-1) begin
        ctrl[g].next_is_len = links[PAT_MAX].in_ok;
      end else begin
        ctrl[g].next_is_len = stat[(g+1) % PAT_MAX].is_len;
      end
    end

    wpm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .link_i (links[g]),
      .link_o (links[g+1]),
      .stat_o (stat[g])
    );
  end

  // accept position beyond the last cell
  assign c1_acc = acc_q || links[PAT_MAX].c1_carry;
  assign c2_acc = links[PAT_MAX].adv || links[PAT_MAX].c2_carry;

  // accept position and end anchor checks over the row
  always_comb begin
    m_pre      = links[PAT_MAX].in_ok && c1_acc;
    m_post     = links[PAT_MAX].in_ok && c2_acc;
    dollar_hit = 1'b0;
    for (int i = 0; i < PAT_MAX; i++) begin
      m_pre      = m_pre      || (stat[i].is_len && stat[i].c1);
      m_post     = m_post     || (stat[i].is_len && stat[i].c2);
      dollar_hit = dollar_hit || (stat[i].dollar && stat[i].c1);
    end
  end

  assign result = match_seen_q || m_pre || dollar_hit;

  // text state update
  always_comb begin
    text_started_d = text_started_q;
    match_seen_d   = match_seen_q;
    acc_d          = acc_q;
    if (do_text) begin
      text_started_d = 1'b1;
      match_seen_d   = match_seen_q || m_pre || m_post;
      acc_d          = c2_acc;
    end else if (do_end) begin
      text_started_d = 1'b0;
      match_seen_d   = 1'b0;
      acc_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_started_q <= 1'b0;
      match_seen_q   <= 1'b0;
      acc_q          <= 1'b0;
    end else begin
      text_started_q <= text_started_d;
      match_seen_q   <= match_seen_d;
      acc_q          <= acc_d;
    end
  end

  // result buffer: output register with one skid entry
  assign pop = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (do_end) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (do_end) begin
      if (!out_valid_q || pop) begin
        out_data_q <= result;
      end else begin
        skid_data_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_data_q};

`ifndef NO_ASSERTIONS
  // skid entry only fills behind a held output
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // end of text leaves no text state behind
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_end |=> (!text_started_q && !match_seen_q && !acc_q))
    else $error("text state not cleared after end of text");

  // a text byte always marks the text as started
  a_text_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_text |=> text_started_q)
    else $error("text not marked started after text byte");

  // every end of text produces a buffered result
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_end |=> out_valid_q)
    else $error("end of text gave no result");
`endif

endmodule

`default_nettype wire
